// File: sv/sv39w_pkg.sv
// Shared types and constants for the Sv39 page table walker.
package sv39w_pkg;

  localparam int unsigned DEF_TABLE_PAGES  = 16;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned VPN_W            = 9;
  localparam int unsigned PG_SHIFT         = 12;
  localparam int unsigned FLAG_W           = 10;
  localparam int unsigned PPN_W            = 44;
  localparam int unsigned ENTRY_W          = PPN_W + FLAG_W;
  localparam int unsigned VA_W             = 39;
  localparam int unsigned PA_W             = 56;
  localparam int unsigned PAGES_W          = 5;
  localparam int unsigned NODE_MODE_W      = 2;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [PAGES_W-1:0] PAGES_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAGES = 1'b1;

  localparam logic [NODE_MODE_W-1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [NODE_MODE_W-1:0] MODE_MAP       = 2'd1;
  localparam logic [NODE_MODE_W-1:0] MODE_UNMAP     = 2'd2;

  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  localparam logic [FLAG_W-1:0] PTE_V = 10'h001;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_MAPPED = 3'd1,
    ST_REMAP      = 3'd2,
    ST_NO_PAGE    = 3'd3,
    ST_OUTSIDE    = 3'd4
  } status_e;

  typedef struct packed {
    logic [PPN_W-1:0]   base;
    logic [PAGES_W-1:0] pages;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [PA_W-1:0]   phys_addr;
  } res_t;

endpackage

// File: sv/sv39w_store.sv
// Table store RAM: one write port, one read port with registered data.
module sv39w_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned W     = 54
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/sv39w_walk_ctl.sv
// Walk sequencer: store clearing, level walk, page allocation and leaf update.
module sv39w_walk_ctl #(
  parameter int unsigned TABLE_PAGES = sv39w_pkg::DEF_TABLE_PAGES,
  parameter int unsigned DEPTH       = TABLE_PAGES * sv39w_pkg::ENTRIES_PER_PAGE,
  parameter int unsigned AW          = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sv39w_pkg::cfg_t                      cfg,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sv39w_pkg::NODE_MODE_W-1:0]    in_mode,
  input  logic [sv39w_pkg::VA_W-1:0]           in_va,
  input  logic [sv39w_pkg::PPN_W-1:0]          in_ppn,
  input  logic [sv39w_pkg::FLAG_W-1:0]         in_perm,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output sv39w_pkg::res_t                      out_res,
  output logic                                 wr_en,
  output logic [AW-1:0]                        wr_addr,
  output logic [sv39w_pkg::ENTRY_W-1:0]        wr_data,
  output logic                                 rd_en,
  output logic [AW-1:0]                        rd_addr,
  input  logic [sv39w_pkg::ENTRY_W-1:0]        rd_data
);

  localparam int unsigned PW  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NW  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned CW  = (NW > sv39w_pkg::PAGES_W) ? NW : sv39w_pkg::PAGES_W;
  localparam int unsigned VW  = sv39w_pkg::VPN_W;
  localparam int unsigned FW  = sv39w_pkg::FLAG_W;
  localparam int unsigned PPW = sv39w_pkg::PPN_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [VW-1:0] LAST_SLOT = VW'(sv39w_pkg::ENTRIES_PER_PAGE - 1);
  localparam logic [CW-1:0] PAGES_MAX = CW'(TABLE_PAGES);
  localparam logic [PPW-1:0] PAGES_PPN = PPW'(TABLE_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_ALLOC, S_ZERO, S_NEXT, S_LEAF, S_DONE
  } state_t;

  function automatic logic [VW-1:0] vpn_of(input logic [sv39w_pkg::VA_W-1:0] va,
                                           input logic [1:0] lvl);
    logic [VW-1:0] v;
    case (lvl)
      sv39w_pkg::LVL_ROOT: v = va[38:30];
      sv39w_pkg::LVL_MID:  v = va[29:21];
      default:             v = va[20:12];
    endcase
    return v;
  endfunction

  state_t                           state_r, state_nxt;
  logic [sv39w_pkg::NODE_MODE_W-1:0] mode_r, mode_nxt;
  logic [sv39w_pkg::VA_W-1:0]       va_r, va_nxt;
  logic [PPW-1:0]                   ppn_r, ppn_nxt;
  logic [FW-1:0]                    perm_r, perm_nxt;
  logic [1:0]                       lvl_r, lvl_nxt;
  logic [PW-1:0]                    page_r, page_nxt;
  logic [PW-1:0]                    newpage_r, newpage_nxt;
  logic [AW-1:0]                    slot_r, slot_nxt;
  logic [AW-1:0]                    cnt_r, cnt_nxt;
  logic [NW-1:0]                    nf_r, nf_nxt;
  logic [TABLE_PAGES-1:0]           dirty_r, dirty_nxt;
  sv39w_pkg::res_t                  res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  sv39w_pkg::res_t                  out_res_r, out_res_nxt;

  logic [PPW-1:0] rel;
  logic [CW-1:0]  lim;
  logic [1:0]     lvl_dn;

  always_comb begin
    rel    = rd_data[sv39w_pkg::ENTRY_W-1:FW] - cfg.base;
    lim    = (CW'(cfg.pages) < PAGES_MAX) ? CW'(cfg.pages) : PAGES_MAX;
    lvl_dn = lvl_r - 2'd1;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    va_nxt        = va_r;
    ppn_nxt       = ppn_r;
    perm_nxt      = perm_r;
    lvl_nxt       = lvl_r;
    page_nxt      = page_r;
    newpage_nxt   = newpage_r;
    cnt_nxt       = cnt_r;
    nf_nxt        = nf_r;
    dirty_nxt     = dirty_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    in_tready     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = slot_r;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt          = in_mode;
          va_nxt            = in_va;
          ppn_nxt           = in_ppn;
          perm_nxt          = in_perm;
          res_nxt.phys_addr = '0;
          if (in_mode == sv39w_pkg::MODE_TRANSLATE || in_mode == sv39w_pkg::MODE_MAP ||
              in_mode == sv39w_pkg::MODE_UNMAP) begin
            rd_en     = 1'b1;
            rd_addr   = AW'({PW'(0), vpn_of(in_va, sv39w_pkg::LVL_ROOT)});
            page_nxt  = '0;
            lvl_nxt   = sv39w_pkg::LVL_ROOT;
            state_nxt = S_EVAL;
          end else begin
            res_nxt.status = sv39w_pkg::ST_NOT_MAPPED;
            state_nxt      = S_DONE;
          end
        end
      end
      S_EVAL: begin
        if (rd_data[0]) begin
          if (rel >= PAGES_PPN) begin
            res_nxt.status = sv39w_pkg::ST_OUTSIDE;
            state_nxt      = S_DONE;
          end else begin
            page_nxt  = rel[PW-1:0];
            lvl_nxt   = lvl_dn;
            rd_en     = 1'b1;
            rd_addr   = AW'({rel[PW-1:0], vpn_of(va_r, lvl_dn)});
            state_nxt = (lvl_dn == sv39w_pkg::LVL_LEAF) ? S_LEAF : S_EVAL;
          end
        end else if (mode_r != sv39w_pkg::MODE_MAP) begin
          res_nxt.status = sv39w_pkg::ST_NOT_MAPPED;
          state_nxt      = S_DONE;
        end else if (CW'(nf_r) >= lim) begin
          res_nxt.status = sv39w_pkg::ST_NO_PAGE;
          state_nxt      = S_DONE;
        end else begin
          newpage_nxt = PW'(nf_r);
          nf_nxt      = nf_r + 1'b1;
          state_nxt   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        wr_en            = 1'b1;
        wr_data          = {cfg.base + PPW'(newpage_r), sv39w_pkg::PTE_V};
        dirty_nxt[page_r] = 1'b1;
        page_nxt         = newpage_r;
        lvl_nxt          = lvl_dn;
        cnt_nxt          = '0;
        state_nxt        = dirty_r[newpage_r] ? S_ZERO : S_NEXT;
      end
      S_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = AW'({page_r, cnt_r[VW-1:0]});
        // the pointer into the new page may sit in that page itself
        if (wr_addr == slot_r) begin
          wr_data = {cfg.base + PPW'(newpage_r), sv39w_pkg::PTE_V};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[VW-1:0] == LAST_SLOT) begin
          dirty_nxt[page_r] = 1'b0;
          state_nxt         = S_NEXT;
        end
      end
      S_NEXT: begin
        rd_en     = 1'b1;
        rd_addr   = AW'({page_r, vpn_of(va_r, lvl_r)});
        state_nxt = (lvl_r == sv39w_pkg::LVL_LEAF) ? S_LEAF : S_EVAL;
      end
      S_LEAF: begin
        state_nxt      = S_DONE;
        res_nxt.status = sv39w_pkg::ST_OK;
        case (mode_r)
          sv39w_pkg::MODE_TRANSLATE: begin
            res_nxt.phys_addr = {rd_data[sv39w_pkg::ENTRY_W-1:FW],
                                 sv39w_pkg::PG_SHIFT'(0)};
          end
          sv39w_pkg::MODE_MAP: begin
            if (rd_data[0]) begin
              res_nxt.status = sv39w_pkg::ST_REMAP;
            end else begin
              wr_en             = 1'b1;
              wr_data           = {ppn_r, perm_r | sv39w_pkg::PTE_V};
              dirty_nxt[page_r] = 1'b1;
            end
          end
          sv39w_pkg::MODE_UNMAP: begin
            if (!rd_data[0]) begin
              res_nxt.status = sv39w_pkg::ST_NOT_MAPPED;
            end else begin
              res_nxt.phys_addr = {rd_data[sv39w_pkg::ENTRY_W-1:FW],
                                   sv39w_pkg::PG_SHIFT'(0)};
              wr_en             = 1'b1;
              dirty_nxt[page_r] = 1'b1;
            end
          end
          default: res_nxt.status = sv39w_pkg::ST_NOT_MAPPED;
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    slot_nxt = rd_en ? rd_addr : slot_r;
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    va_r      <= va_nxt;
    ppn_r     <= ppn_nxt;
    perm_r    <= perm_nxt;
    lvl_r     <= lvl_nxt;
    page_r    <= page_nxt;
    newpage_r <= newpage_nxt;
    slot_r    <= slot_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      nf_r        <= NW'(1);
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nf_r        <= nf_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  // no request taken until the reset clear has swept the whole store
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request accepted during store clear");

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(nf_r) <= PAGES_MAX) && (nf_r != '0))
    else $error("allocator out of range");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && state_nxt == S_ALLOC) |=> (nf_r == $past(nf_r) + 1'b1))
    else $error("allocator did not advance by one page");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("store written outside a walk");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");

endmodule

// File: sv/sv39_page_table_walker.sv
// Sv39 page table walker top level: ports, configuration registers, store and sequencer.
// One request is handled at a time. After reset the block sweeps the whole table store to
// zero, one entry per cycle, and takes no request until that is done. A request then goes
// from acceptance to its result word being offered through a root entry check, a middle
// entry check, a leaf check and update, and a result load; each table read comes back
// registered from the store. A map adds an allocation step and a re-read step for each table
// page it allocates, plus a sweep of that page to zero when an allocated page had been written
// before and must be zeroed first. Requests that end early or carry an unknown mode finish sooner.
// The next request is accepted in the cycle after the result is loaded, while that result
// may still wait on the output; a further result cannot be loaded until the waiting one
// has gone.
module sv39_page_table_walker #(
  parameter int unsigned TABLE_PAGES = sv39w_pkg::DEF_TABLE_PAGES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sv39w_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sv39w_pkg::PPN_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // virt_addr[38:0], phys_page[82:39], perm_bits[92:83], zero fill
  input  logic [95:0]                       in_tdata,
  // mode[1:0]
  input  logic [sv39w_pkg::NODE_MODE_W-1:0] in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // phys_addr[55:0]
  output logic [sv39w_pkg::PA_W-1:0]        out_tdata,
  // status[2:0]
  output logic [sv39w_pkg::STATUS_W-1:0]    out_tuser
);

  localparam int unsigned DEPTH = TABLE_PAGES * sv39w_pkg::ENTRIES_PER_PAGE;
  localparam int unsigned AW    = $clog2(DEPTH);

  sv39w_pkg::cfg_t cfg_r;
  sv39w_pkg::res_t res;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [sv39w_pkg::ENTRY_W-1:0] wr_data;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [sv39w_pkg::ENTRY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base  <= '0;
      cfg_r.pages <= sv39w_pkg::PAGES_RST;
    end else if (cfg_we) begin
      if (cfg_index == sv39w_pkg::CFG_IDX_BASE) begin
        cfg_r.base <= cfg_wdata;
      end
      if (cfg_index == sv39w_pkg::CFG_IDX_PAGES) begin
        cfg_r.pages <= cfg_wdata[sv39w_pkg::PAGES_W-1:0];
      end
    end
  end

  sv39w_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (sv39w_pkg::ENTRY_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sv39w_walk_ctl #(
    .TABLE_PAGES (TABLE_PAGES),
    .DEPTH       (DEPTH),
    .AW          (AW)
  ) u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .in_va      (in_tdata[38:0]),
    .in_ppn     (in_tdata[82:39]),
    .in_perm    (in_tdata[92:83]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  assign out_tdata = res.phys_addr;
  assign out_tuser = res.status;

endmodule
